[sv/ssi_pkg.sv]
// Shared widths and stage bundles for the segment/sphere intersection pipeline.
package ssi_pkg;

	localparam int COORD_W = 32;                 // Q16.16 coordinate
	localparam int DIFF_W  = COORD_W + 1;        // end - start, centre - start
	localparam int SQ_W    = 2 * DIFF_W - 1;     // square of a difference
	localparam int PROD_W  = 2 * DIFF_W;         // signed product of two differences
	localparam int SUM_W   = SQ_W + 1;           // sum of three squares
	localparam int DOT_W   = PROD_W + 1;         // signed sum of three products
	localparam int RSQ_W   = 2 * COORD_W - 1;    // radius squared
	localparam int HALF_W  = SUM_W / 2;          // partial product operand width
	localparam int WIDE_W  = 2 * SUM_W;          // full wide product

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] start_z;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] end_z;
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] center_z;
		logic signed [COORD_W-1:0] radius;
	} ssi_query_t;

	typedef struct packed {
		logic        [SUM_W-1:0] lsq;    // |d|^2
		logic        [SUM_W-1:0] wsq;    // |w|^2
		logic signed [DOT_W-1:0] dot;    // w.d
		logic        [RSQ_W-1:0] rsq;    // r^2
	} ssi_sums_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} ssi_front_en_t;

	typedef struct packed {
		logic s1;
		logic s2;
	} ssi_mul_en_t;

endpackage

[sv/ssi_seg_if.sv]
// Input channel: one segment/sphere query per item.
interface ssi_seg_if;
	logic                                valid;
	logic                                ready;
	logic signed [ssi_pkg::COORD_W-1:0] start_x;
	logic signed [ssi_pkg::COORD_W-1:0] start_y;
	logic signed [ssi_pkg::COORD_W-1:0] start_z;
	logic signed [ssi_pkg::COORD_W-1:0] end_x;
	logic signed [ssi_pkg::COORD_W-1:0] end_y;
	logic signed [ssi_pkg::COORD_W-1:0] end_z;
	logic signed [ssi_pkg::COORD_W-1:0] center_x;
	logic signed [ssi_pkg::COORD_W-1:0] center_y;
	logic signed [ssi_pkg::COORD_W-1:0] center_z;
	logic signed [ssi_pkg::COORD_W-1:0] radius;

	modport source (
		output valid, start_x, start_y, start_z, end_x, end_y, end_z,
			center_x, center_y, center_z, radius,
		input  ready
	);
	modport sink (
		input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
			center_x, center_y, center_z, radius,
		output ready
	);
endinterface

[sv/ssi_res_if.sv]
// Output channel: one hit flag per item.
interface ssi_res_if;
	logic valid;
	logic ready;
	logic hit;

	modport source (output valid, hit, input ready);
	modport sink (input valid, hit, output ready);
endinterface

[sv/segment_sphere_intersect_top.sv]
// Segment/sphere hit test: six register stages, one item per cycle while the output is taken.
// Accepts one query per clock while the output side does not stall, and returns one
// hit flag per query. The rate is set by the fully
// pipelined multipliers: stage 2 forms the per-axis products with 33x33 multipliers,
// stages 4 and 5 form W*L, R*L and D*D exactly from half-width partial products, and
// stage 6 compares W*L against R*L + D*D. Every stage holds its item while the next
// one is full and stalled, so bubbles close up and backpressure reaches the input only
// when all stages hold items. A hit needs a nonzero segment, 0 <= D <= L and the
// distance test; touching the radius or a segment end counts as a hit.
module segment_sphere_intersect_top (
	input  logic      clk,
	input  logic      arst_n,
	ssi_seg_if.sink   seg,
	ssi_res_if.source res
);

	ssi_pkg::ssi_query_t   query;
	ssi_pkg::ssi_sums_t    sums;
	ssi_pkg::ssi_front_en_t front_en;
	ssi_pkg::ssi_mul_en_t   mul_en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	logic pre_ok_s4, pre_ok_s5, hit_s6;
	logic pre_ok_d;

	logic [ssi_pkg::WIDE_W-1:0] wl_p, rl_p, dd_p;
	logic [ssi_pkg::WIDE_W:0]   rhs;
	logic                       hit_d;

	// a stage moves when it is empty or the next one moves
	assign en6 = !v_s6 || res.ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign seg.ready = en1;

	assign front_en.s1 = en1;
	assign front_en.s2 = en2;
	assign front_en.s3 = en3;
	assign mul_en.s1   = en4;
	assign mul_en.s2   = en5;

	assign query.start_x  = seg.start_x;
	assign query.start_y  = seg.start_y;
	assign query.start_z  = seg.start_z;
	assign query.end_x    = seg.end_x;
	assign query.end_y    = seg.end_y;
	assign query.end_z    = seg.end_z;
	assign query.center_x = seg.center_x;
	assign query.center_y = seg.center_y;
	assign query.center_z = seg.center_z;
	assign query.radius   = seg.radius;

	ssi_front u_front (
		.clk  (clk),
		.en   (front_en),
		.q    (query),
		.sums (sums)
	);

	ssi_wmul u_wl (
		.clk (clk),
		.en  (mul_en),
		.a   (sums.wsq),
		.b   (sums.lsq),
		.p   (wl_p)
	);

	ssi_wmul u_rl (
		.clk (clk),
		.en  (mul_en),
		.a   (ssi_pkg::SUM_W'(sums.rsq)),
		.b   (sums.lsq),
		.p   (rl_p)
	);

	// only used when D >= 0, so its low bits are its magnitude
	ssi_wmul u_dd (
		.clk (clk),
		.en  (mul_en),
		.a   (sums.dot[ssi_pkg::SUM_W-1:0]),
		.b   (sums.dot[ssi_pkg::SUM_W-1:0]),
		.p   (dd_p)
	);

	assign pre_ok_d = (sums.lsq != '0) && !sums.dot[ssi_pkg::DOT_W-1]
		&& (sums.dot[ssi_pkg::SUM_W-1:0] <= sums.lsq);

	assign rhs   = (ssi_pkg::WIDE_W+1)'(rl_p) + (ssi_pkg::WIDE_W+1)'(dd_p);
	assign hit_d = pre_ok_s5 && ({1'b0, wl_p} <= rhs);

	always_ff @(posedge clk) begin
		if (en4) begin
			pre_ok_s4 <= pre_ok_d;
		end
		if (en5) begin
			pre_ok_s5 <= pre_ok_s4;
		end
		if (en6) begin
			hit_s6 <= hit_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= seg.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	assign res.valid = v_s6;
	assign res.hit   = hit_s6;

	// an item that fails the range checks never reports a hit
	a_no_hit_when_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !pre_ok_s5 && en6 |=> !res.hit)
		else $error("hit reported for an item outside the segment range");

	// a taken output frees the whole pipeline for a new item
	a_ready_passes_back: assert property (@(posedge clk) disable iff (!arst_n)
		res.ready |-> seg.ready)
		else $error("input stalled while the output is being taken");

	// a full, stalled pipeline must push back on the input
	a_full_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && res.valid && !res.ready |-> !seg.ready)
		else $error("item taken while every stage is full and stalled");

endmodule

[sv/ssi_front.sv]
// Stages 1-3: differences, per-axis products, and the four sums L, W, D, R.
module ssi_front (
	input  logic                   clk,
	input  ssi_pkg::ssi_front_en_t en,
	input  ssi_pkg::ssi_query_t    q,
	output ssi_pkg::ssi_sums_t     sums
);

	logic signed [ssi_pkg::COORD_W-1:0] sv [3];
	logic signed [ssi_pkg::COORD_W-1:0] ev [3];
	logic signed [ssi_pkg::COORD_W-1:0] cv [3];

	logic signed [ssi_pkg::DIFF_W-1:0]  d_s1 [3];
	logic signed [ssi_pkg::DIFF_W-1:0]  w_s1 [3];
	logic        [ssi_pkg::COORD_W-1:0] rabs_s1;

	logic signed [ssi_pkg::PROD_W-1:0]  dd_p [3];
	logic signed [ssi_pkg::PROD_W-1:0]  ww_p [3];
	logic signed [ssi_pkg::PROD_W-1:0]  wd_p [3];
	logic        [2*ssi_pkg::COORD_W-1:0] rr_p;

	logic        [ssi_pkg::SQ_W-1:0]    dd_s2 [3];
	logic        [ssi_pkg::SQ_W-1:0]    ww_s2 [3];
	logic signed [ssi_pkg::PROD_W-1:0]  wd_s2 [3];
	logic        [ssi_pkg::RSQ_W-1:0]   rr_s2;

	ssi_pkg::ssi_sums_t sums_s3;

	assign sv[0] = q.start_x;
	assign sv[1] = q.start_y;
	assign sv[2] = q.start_z;
	assign ev[0] = q.end_x;
	assign ev[1] = q.end_y;
	assign ev[2] = q.end_z;
	assign cv[0] = q.center_x;
	assign cv[1] = q.center_y;
	assign cv[2] = q.center_z;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= {ev[i][ssi_pkg::COORD_W-1], ev[i]} - {sv[i][ssi_pkg::COORD_W-1], sv[i]};
				w_s1[i] <= {cv[i][ssi_pkg::COORD_W-1], cv[i]} - {sv[i][ssi_pkg::COORD_W-1], sv[i]};
			end
			// magnitude; the most negative value maps to 2^31 as unsigned
			rabs_s1 <= q.radius[ssi_pkg::COORD_W-1] ? $unsigned(~q.radius + 1'b1)
				: $unsigned(q.radius);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dd_p[i] = d_s1[i] * d_s1[i];
			ww_p[i] = w_s1[i] * w_s1[i];
			wd_p[i] = w_s1[i] * d_s1[i];
		end
		rr_p = rabs_s1 * rabs_s1;
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= dd_p[i][ssi_pkg::SQ_W-1:0];
				ww_s2[i] <= ww_p[i][ssi_pkg::SQ_W-1:0];
				wd_s2[i] <= wd_p[i];
			end
			rr_s2 <= rr_p[ssi_pkg::RSQ_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			sums_s3.lsq <= ssi_pkg::SUM_W'(dd_s2[0]) + ssi_pkg::SUM_W'(dd_s2[1])
				+ ssi_pkg::SUM_W'(dd_s2[2]);
			sums_s3.wsq <= ssi_pkg::SUM_W'(ww_s2[0]) + ssi_pkg::SUM_W'(ww_s2[1])
				+ ssi_pkg::SUM_W'(ww_s2[2]);
			sums_s3.dot <= ssi_pkg::DOT_W'(wd_s2[0]) + ssi_pkg::DOT_W'(wd_s2[1])
				+ ssi_pkg::DOT_W'(wd_s2[2]);
			sums_s3.rsq <= rr_s2;
		end
	end

	assign sums = sums_s3;

endmodule

[sv/ssi_wmul.sv]
// Two-stage unsigned wide multiplier built from four half-width partial products.
module ssi_wmul (
	input  logic                        clk,
	input  ssi_pkg::ssi_mul_en_t        en,
	input  logic [ssi_pkg::SUM_W-1:0]   a,
	input  logic [ssi_pkg::SUM_W-1:0]   b,
	output logic [ssi_pkg::WIDE_W-1:0]  p
);

	localparam int H = ssi_pkg::HALF_W;

	logic [2*H-1:0]              ll_s1, lh_s1, hl_s1, hh_s1;
	logic [ssi_pkg::WIDE_W-1:0]  p_s2;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			ll_s1 <= a[H-1:0]               * b[H-1:0];
			lh_s1 <= a[H-1:0]               * b[ssi_pkg::SUM_W-1:H];
			hl_s1 <= a[ssi_pkg::SUM_W-1:H]  * b[H-1:0];
			hh_s1 <= a[ssi_pkg::SUM_W-1:H]  * b[ssi_pkg::SUM_W-1:H];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			p_s2 <= (ssi_pkg::WIDE_W'(hh_s1) << (2 * H))
				+ ((ssi_pkg::WIDE_W'(lh_s1) + ssi_pkg::WIDE_W'(hl_s1)) << H)
				+ ssi_pkg::WIDE_W'(ll_s1);
		end
	end

	assign p = p_s2;

endmodule

[tb/segment_sphere_intersect_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the segment/sphere hit pipeline: directed table, then random queries.
module segment_sphere_intersect_top_tb;

	localparam int Q1   = 65536;            // 1.0 in Q16.16
	localparam int QMIN = 32'h8000_0000;
	localparam int QMAX = 32'h7fff_ffff;
	localparam int NUM_DIRECTED = 20;
	localparam int RANDOM_PER_PHASE = 177;
	localparam int TAIL_CYCLES = 16;
	localparam real RUN_LIMIT_NS = 4_000_000.0;

	typedef logic signed [199:0] wide_t;

	typedef enum logic [1:0] {FROM_PREDICTOR, KNOWN_MISS, KNOWN_HIT} row_check_t;

	typedef struct {
		int         sx, sy, sz;
		int         ex, ey, ez;
		int         cx, cy, cz;
		int         r;
		row_check_t chk;
	} query_row_t;

	logic clk;
	logic arst_n;

	ssi_seg_if seg();
	ssi_res_if res();

	segment_sphere_intersect_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.seg    (seg),
		.res    (res)
	);

	query_row_t directed_rows[NUM_DIRECTED];
	bit         pending_hits[$];
	int         send_idle_pct;
	int         recv_idle_pct;
	int         mismatch_count;
	int         result_count;

	always #10 clk = ~clk;

	// Exact segment/sphere test in wide signed integers, no division.
	function automatic bit predict_hit(input ssi_pkg::ssi_query_t q);
		longint dv[3];
		longint wv[3];
		wide_t  len_sq, w_sq, dot, r_sq;
		dv[0] = longint'(q.end_x) - longint'(q.start_x);
		dv[1] = longint'(q.end_y) - longint'(q.start_y);
		dv[2] = longint'(q.end_z) - longint'(q.start_z);
		wv[0] = longint'(q.center_x) - longint'(q.start_x);
		wv[1] = longint'(q.center_y) - longint'(q.start_y);
		wv[2] = longint'(q.center_z) - longint'(q.start_z);
		len_sq = '0;
		w_sq   = '0;
		dot    = '0;
		for (int i = 0; i < 3; i++) begin
			len_sq += wide_t'(dv[i]) * wide_t'(dv[i]);
			w_sq   += wide_t'(wv[i]) * wide_t'(wv[i]);
			dot    += wide_t'(wv[i]) * wide_t'(dv[i]);
		end
		r_sq = wide_t'(longint'(q.radius)) * wide_t'(longint'(q.radius));
		return (len_sq != 0) && (dot >= 0) && (dot <= len_sq)
			&& (w_sq * len_sq <= r_sq * len_sq + dot * dot);
	endfunction

	function automatic int corner_value();
		case ($urandom_range(5))
			0: return QMIN;
			1: return QMAX;
			2: return 0;
			3: return -1;
			4: return 1;
			default: return int'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic send_query(input ssi_pkg::ssi_query_t q, input row_check_t chk);
		while ($urandom_range(99) < send_idle_pct) begin
			seg.valid <= 1'b0;
			@(posedge clk);
		end
		seg.valid    <= 1'b1;
		seg.start_x  <= q.start_x;
		seg.start_y  <= q.start_y;
		seg.start_z  <= q.start_z;
		seg.end_x    <= q.end_x;
		seg.end_y    <= q.end_y;
		seg.end_z    <= q.end_z;
		seg.center_x <= q.center_x;
		seg.center_y <= q.center_y;
		seg.center_z <= q.center_z;
		seg.radius   <= q.radius;
		do @(posedge clk); while (!seg.ready);
		case (chk)
			KNOWN_HIT:  pending_hits = {pending_hits, 1'b1};
			KNOWN_MISS: pending_hits = {pending_hits, 1'b0};
			default:    pending_hits = {pending_hits, predict_hit(q)};
		endcase
	endtask

	task automatic drain_results();
		seg.valid <= 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random_phase(input int count, input int send_pct, input int recv_pct);
		int                  s[3], e[3], c[3];
		int                  r, mode, k;
		ssi_pkg::ssi_query_t q;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count) begin
			mode = $urandom_range(99);
			r = int'($urandom);
			if (mode < 40) begin
				// short segment, centre near a point along it (some just past the ends)
				k = int'($urandom_range(0, 18)) - 1;
				for (int i = 0; i < 3; i++) begin
					s[i] = int'($urandom_range(0, 1 << 21)) - (1 << 20);
					e[i] = s[i] + int'($urandom_range(0, 1 << 21)) - (1 << 20);
					c[i] = s[i] + ((e[i] - s[i]) * k) / 16
						+ int'($urandom_range(0, 1 << 12)) - (1 << 11);
				end
				r = int'($urandom_range(0, 1 << 13));
				if ($urandom_range(3) == 0)
					r = -r;
			end else if (mode < 55) begin
				for (int i = 0; i < 3; i++) begin
					s[i] = int'($urandom);
					e[i] = int'($urandom);
					c[i] = int'($urandom);
				end
			end else if (mode < 65) begin
				// zero-length segment
				for (int i = 0; i < 3; i++) begin
					s[i] = int'($urandom);
					e[i] = s[i];
					c[i] = ($urandom_range(1) != 0) ? s[i] : int'($urandom);
				end
			end else if (mode < 80) begin
				// integer grid: lands exactly on touching and end-point cases
				for (int i = 0; i < 3; i++) begin
					s[i] = (int'($urandom_range(0, 8)) - 4) * Q1;
					e[i] = (int'($urandom_range(0, 8)) - 4) * Q1;
					c[i] = (int'($urandom_range(0, 8)) - 4) * Q1;
				end
				r = (int'($urandom_range(0, 8)) - 4) * Q1;
			end else if (mode < 90) begin
				for (int i = 0; i < 3; i++) begin
					s[i] = corner_value();
					e[i] = corner_value();
					c[i] = corner_value();
				end
				r = corner_value();
			end else begin
				for (int i = 0; i < 3; i++) begin
					s[i] = int'($urandom_range(0, 6)) - 3;
					e[i] = int'($urandom_range(0, 6)) - 3;
					c[i] = int'($urandom_range(0, 6)) - 3;
				end
				r = int'($urandom_range(0, 6)) - 3;
			end
			q.start_x  = s[0];
			q.start_y  = s[1];
			q.start_z  = s[2];
			q.end_x    = e[0];
			q.end_y    = e[1];
			q.end_z    = e[2];
			q.center_x = c[0];
			q.center_y = c[1];
			q.center_z = c[2];
			q.radius   = r;
			send_query(q, FROM_PREDICTOR);
		end
		drain_results();
	endtask

	// result checker and output backpressure
	always @(posedge clk) begin : result_check
		bit want;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				result_count++;
				if (pending_hits.size() == 0) begin
					report_mismatch($sformatf("result %0d: hit=%0b with no query pending",
						result_count, res.hit));
				end else begin
					want = pending_hits.pop_front();
					if (res.hit !== want)
						report_mismatch($sformatf("result %0d: hit=%0b, expected %0b",
							result_count, res.hit, want));
				end
			end
		end
		res.ready <= arst_n ? ($urandom_range(99) >= recv_idle_pct) : 1'b0;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		ssi_pkg::ssi_query_t q;
		clk            = 1'b0;
		arst_n         = 1'b0;
		mismatch_count = 0;
		result_count   = 0;
		send_idle_pct  = 29;
		recv_idle_pct  = 84;
		seg.valid      = 1'b0;
		seg.start_x    = '0;
		seg.start_y    = '0;
		seg.start_z    = '0;
		seg.end_x      = '0;
		seg.end_y      = '0;
		seg.end_z      = '0;
		seg.center_x   = '0;
		seg.center_y   = '0;
		seg.center_z   = '0;
		seg.radius     = '0;

		directed_rows = '{
			// zero-length segments never hit
			'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, KNOWN_MISS},
			'{3*Q1, -2*Q1, Q1, 3*Q1, -2*Q1, Q1, 3*Q1, -2*Q1, Q1, 5*Q1, KNOWN_MISS},
			'{QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, KNOWN_MISS},
			'{0, 0, 0, 10*Q1, 0, 0, 5*Q1, Q1, 0, 2*Q1, KNOWN_HIT},
			// centre behind the start / past the end, a segment end point inside sphere
			'{0, 0, 0, 10*Q1, 0, 0, -Q1, 0, 0, 5*Q1, KNOWN_MISS},
			'{0, 0, 0, 10*Q1, 0, 0, 11*Q1, 0, 0, 5*Q1, KNOWN_MISS},
			'{0, 0, 0, 10*Q1, 0, 0, 5*Q1, Q1, 0, -2*Q1, KNOWN_HIT},
			// distance equal to the radius, then one LSB short
			'{0, 0, 0, 10*Q1, 0, 0, 5*Q1, 2*Q1, 0, 2*Q1, KNOWN_HIT},
			'{0, 0, 0, 10*Q1, 0, 0, 5*Q1, 2*Q1, 0, 2*Q1 - 1, KNOWN_MISS},
			// projection exactly on either end
			'{0, 0, 0, 10*Q1, 0, 0, 0, 3*Q1, 0, 3*Q1, KNOWN_HIT},
			'{0, 0, 0, 10*Q1, 0, 0, 10*Q1, 3*Q1, 0, 3*Q1, KNOWN_HIT},
			'{0, 0, 0, 10*Q1, 0, 0, 4*Q1, 0, 0, 0, KNOWN_HIT},
			'{-Q1, -Q1, -Q1, Q1, Q1, Q1, 0, Q1, 0, Q1, FROM_PREDICTOR},
			'{QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, 0, 0, 0, QMAX, FROM_PREDICTOR},
			'{QMAX, QMAX, QMAX, QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, QMIN, FROM_PREDICTOR},
			'{QMIN, QMIN, QMIN, QMAX, QMAX, QMAX, QMAX, QMIN, QMAX, 1, FROM_PREDICTOR},
			'{QMIN, 0, QMAX, QMAX, 0, QMIN, -1, -1, -1, -1, FROM_PREDICTOR},
			'{0, 0, 0, 1, 0, 0, 1, 1, 0, 1, FROM_PREDICTOR},
			'{0, -7*Q1, 0, 0, 7*Q1, 0, 0, 0, 3*Q1, 3*Q1, FROM_PREDICTOR},
			'{2*Q1, 2*Q1, -Q1, 2*Q1, 2*Q1, -9*Q1, 3*Q1, 2*Q1, -5*Q1, Q1, FROM_PREDICTOR}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			q.start_x  = directed_rows[i].sx;
			q.start_y  = directed_rows[i].sy;
			q.start_z  = directed_rows[i].sz;
			q.end_x    = directed_rows[i].ex;
			q.end_y    = directed_rows[i].ey;
			q.end_z    = directed_rows[i].ez;
			q.center_x = directed_rows[i].cx;
			q.center_y = directed_rows[i].cy;
			q.center_z = directed_rows[i].cz;
			q.radius   = directed_rows[i].r;
			send_query(q, directed_rows[i].chk);
		end
		// hold the input until the pipe has emptied
		drain_results();

		run_random_phase(RANDOM_PER_PHASE, 29, 84);
		run_random_phase(RANDOM_PER_PHASE, 84, 29);
		run_random_phase(RANDOM_PER_PHASE, 0, 0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
